FILE: sv/bdp_pkg.sv
// shared constants, codes and controller/datapath types for the branch predictor
`timescale 1ns / 1ps
`default_nettype none

package bdp_pkg;

  // default sizes of the storage
  localparam int MaxIndexBitsDef   = 10;
  localparam int MaxHistoryBitsDef = 6;
  localparam int MaxCounterBitsDef = 4;

  // stream words
  localparam int InDataW    = 72;
  localparam int OutDataW   = 72;
  localparam int InTakenBit = 64;
  localparam int CntW       = 32;

  // configuration port and register widths
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 4;
  localparam int ModeW    = 2;
  localparam int IbW      = 4;
  localparam int HbW      = 3;
  localparam int CbW      = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgMode        = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgIndexBits   = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgHistoryBits = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgCounterBits = 4'd3;
  localparam logic [CfgIdxW-1:0] CfgRegCount    = 4'd4;

  typedef enum logic [ModeW-1:0] {
    ModeBimodal  = 2'd0,
    ModeGshare   = 2'd1,
    ModeLocal    = 2'd2,
    ModeTwoLevel = 2'd3
  } mode_e;

  // register reset values
  localparam mode_e          ModeRst = ModeBimodal;
  localparam logic [IbW-1:0] IbRst   = 4'd10;
  localparam logic [HbW-1:0] HbRst   = 3'd6;
  localparam logic [CbW-1:0] CbRst   = 3'd2;

  typedef enum logic [3:0] {
    StClear = 4'b0001,
    StIdle  = 4'b0010,
    StHist  = 4'b0100,
    StCtr   = 4'b1000
  } state_e;

  typedef struct packed {
    logic clr_start; // restart the table sweep, clear global history
    logic clr_step;  // write one sweep entry
    logic cfg_we;    // store configuration word
    logic accept;    // latch input word, read local history
    logic slot_rd;   // form table slot, read counter
    logic commit;    // train, update histories and counts, load result
  } bdp_cmd_t;

  typedef struct packed {
    logic clr_last;  // sweep is on its final entry
  } bdp_sts_t;

endpackage

`default_nettype wire

FILE: sv/bdp_ctrl.sv
// controller state machine for the branch predictor
`timescale 1ns / 1ps
`default_nettype none

module bdp_ctrl (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire  [bdp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire  bdp_pkg::bdp_sts_t        sts_i,
  output bdp_pkg::bdp_cmd_t              cmd_o
);

  bdp_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            cfg_known;
  logic            out_free;

  assign cfg_ready_o = 1'b1;
  assign cfg_known   = cfg_valid_i && (cfg_index_i < bdp_pkg::CfgRegCount);
  assign out_free    = !out_valid_q || m_axis_tready;

  always_comb begin
    cmd_o         = '0;
    state_d       = state_q;
    s_axis_tready = 1'b0;
    cmd_o.cfg_we  = cfg_valid_i;
    case (state_q)
      bdp_pkg::StClear: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = bdp_pkg::StIdle;
        end
      end
      bdp_pkg::StIdle: begin
        // a configuration word takes the cycle
        s_axis_tready = !cfg_valid_i;
        if (s_axis_tvalid && !cfg_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = bdp_pkg::StHist;
        end
      end
      bdp_pkg::StHist: begin
        cmd_o.slot_rd = 1'b1;
        state_d       = bdp_pkg::StCtr;
      end
      bdp_pkg::StCtr: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = bdp_pkg::StIdle;
        end
      end
      default: begin
        state_d = bdp_pkg::StClear;
      end
    endcase
    if (cfg_known) begin
      cmd_o.clr_start = 1'b1;
      cmd_o.clr_step  = 1'b0;
      cmd_o.slot_rd   = 1'b0;
      cmd_o.commit    = 1'b0;
      state_d         = bdp_pkg::StClear;
    end
  end

  assign out_valid_d   = cmd_o.commit || (out_valid_q && !m_axis_tready);
  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdp_pkg::StClear;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/bdp_dpath.sv
// datapath of the branch predictor: config, tables, histories, counts, result
`timescale 1ns / 1ps
`default_nettype none

module bdp_dpath #(
  parameter int MAX_INDEX_BITS   = bdp_pkg::MaxIndexBitsDef,
  parameter int MAX_HISTORY_BITS = bdp_pkg::MaxHistoryBitsDef,
  parameter int MAX_COUNTER_BITS = bdp_pkg::MaxCounterBitsDef
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire  bdp_pkg::bdp_cmd_t         cmd_i,
  output bdp_pkg::bdp_sts_t               sts_o,
  input  wire  [bdp_pkg::InDataW-1:0]     in_data_i,
  input  wire  [bdp_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire  [bdp_pkg::CfgDataW-1:0]    cfg_data_i,
  output logic [bdp_pkg::OutDataW-1:0]    out_data_o
);

  localparam int IdxW       = MAX_INDEX_BITS;
  localparam int HistW      = MAX_HISTORY_BITS;
  localparam int CtrW       = MAX_COUNTER_BITS;
  localparam int SlotW      = IdxW + HistW;
  localparam int TableDepth = 1 << SlotW;
  localparam int LocalDepth = 1 << IdxW;
  localparam int IbW        = bdp_pkg::IbW;
  localparam int HbW        = bdp_pkg::HbW;
  localparam int CbW        = bdp_pkg::CbW;
  localparam int CntW       = bdp_pkg::CntW;
  localparam int OutPadW    = bdp_pkg::OutDataW - 2 - 2 * CntW;

  // configuration registers
  bdp_pkg::mode_e  mode_q;
  logic [IbW-1:0]  ib_q;
  logic [HbW-1:0]  hb_q;
  logic [CbW-1:0]  cb_q;

  // effective widths after clamping
  logic [IbW-1:0]  eff_ib;
  logic [HbW-1:0]  eff_hb;
  logic [CbW-1:0]  eff_cb;

  logic [IdxW-1:0] imask;
  logic [HistW-1:0] hmask;
  logic [CtrW-1:0] cmax;
  logic [CtrW-1:0] ctr_weak;

  // storage
  logic [CtrW-1:0]  ctr_mem   [TableDepth];
  logic [HistW-1:0] lhist_mem [LocalDepth];

  // per-item registers
  logic [IdxW-1:0]  pc_lo_q;
  logic             taken_q;
  logic [HistW-1:0] lhist_rd_q;
  logic [SlotW-1:0] slot_q;
  logic [CtrW-1:0]  ctr_rd_q;

  logic [HistW-1:0] ghist_q;
  logic [SlotW-1:0] clr_addr_q;
  logic [CntW-1:0]  br_cnt_q;
  logic [CntW-1:0]  hit_cnt_q;
  logic             out_pred_q;
  logic             out_hit_q;

  logic [IdxW-1:0]  in_entry;
  logic [IdxW-1:0]  entry;
  logic [HistW-1:0] lhist;
  logic [SlotW-1:0] slot;
  logic             pred;
  logic             hit;
  logic [CtrW-1:0]  ctr_new;
  logic [HistW-1:0] lhist_new;
  logic [HistW-1:0] ghist_new;

  assign eff_ib = (int'(ib_q) > MAX_INDEX_BITS)   ? IbW'(MAX_INDEX_BITS)   : ib_q;
  assign eff_hb = (int'(hb_q) > MAX_HISTORY_BITS) ? HbW'(MAX_HISTORY_BITS) : hb_q;
  assign eff_cb = (cb_q == '0) ? CbW'(1) :
                  ((int'(cb_q) > MAX_COUNTER_BITS) ? CbW'(MAX_COUNTER_BITS) : cb_q);

  always_comb begin
    for (int i = 0; i < IdxW; i++) begin
      imask[i] = (i < int'(eff_ib));
    end
    for (int i = 0; i < HistW; i++) begin
      hmask[i] = (i < int'(eff_hb));
    end
    for (int i = 0; i < CtrW; i++) begin
      cmax[i]     = (i < int'(eff_cb));
      ctr_weak[i] = (i == int'(eff_cb) - 1);
    end
  end

  assign in_entry = in_data_i[IdxW-1:0] & imask;
  assign entry    = pc_lo_q & imask;
  assign lhist    = lhist_rd_q & hmask;

  always_comb begin
    case (mode_q)
      bdp_pkg::ModeBimodal:  slot = SlotW'(entry);
      bdp_pkg::ModeGshare:   slot = SlotW'((pc_lo_q ^ IdxW'(ghist_q & hmask)) & imask);
      bdp_pkg::ModeLocal:    slot = (SlotW'(entry) << eff_hb) | SlotW'(lhist);
      bdp_pkg::ModeTwoLevel: slot = SlotW'(lhist);
      default:               slot = SlotW'(entry);
    endcase
  end

  // prediction and training
  assign pred = (ctr_rd_q >= ctr_weak);
  assign hit  = (pred == taken_q);

  always_comb begin
    ctr_new = ctr_rd_q;
    if (taken_q) begin
      if (ctr_rd_q < cmax) begin
        ctr_new = ctr_rd_q + CtrW'(1);
      end
    end else if (ctr_rd_q != '0) begin
      ctr_new = ctr_rd_q - CtrW'(1);
    end
  end

  assign lhist_new = HistW'({lhist, taken_q}) & hmask;
  assign ghist_new = HistW'({ghist_q, taken_q}) & hmask;

  // pattern table: sweep write or training write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      ctr_mem[clr_addr_q] <= ctr_weak;
    end else if (cmd_i.commit) begin
      ctr_mem[slot_q] <= ctr_new;
    end
    if (cmd_i.slot_rd) begin
      ctr_rd_q <= ctr_mem[slot];
    end
  end

  // local history table, cleared by the same sweep
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      lhist_mem[clr_addr_q[IdxW-1:0]] <= '0;
    end else if (cmd_i.commit && mode_q[1]) begin
      lhist_mem[entry] <= lhist_new;
    end
    if (cmd_i.accept) begin
      lhist_rd_q <= lhist_mem[in_entry];
    end
  end

  // item payload and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pc_lo_q <= in_data_i[IdxW-1:0];
      taken_q <= in_data_i[bdp_pkg::InTakenBit];
    end
    if (cmd_i.slot_rd) begin
      slot_q <= slot;
    end
    if (cmd_i.commit) begin
      out_pred_q <= pred;
      out_hit_q  <= hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= bdp_pkg::ModeRst;
      ib_q       <= bdp_pkg::IbRst;
      hb_q       <= bdp_pkg::HbRst;
      cb_q       <= bdp_pkg::CbRst;
      ghist_q    <= '0;
      clr_addr_q <= '0;
      br_cnt_q   <= '0;
      hit_cnt_q  <= '0;
    end else begin
      if (cmd_i.cfg_we) begin
        case (cfg_index_i)
          bdp_pkg::CfgMode:        mode_q <= bdp_pkg::mode_e'(cfg_data_i[1:0]);
          bdp_pkg::CfgIndexBits:   ib_q   <= cfg_data_i[IbW-1:0];
          bdp_pkg::CfgHistoryBits: hb_q   <= cfg_data_i[HbW-1:0];
          bdp_pkg::CfgCounterBits: cb_q   <= cfg_data_i[CbW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.clr_start) begin
        clr_addr_q <= '0;
        ghist_q    <= '0;
      end else begin
        if (cmd_i.clr_step) begin
          clr_addr_q <= clr_addr_q + SlotW'(1);
        end
        if (cmd_i.commit) begin
          ghist_q <= ghist_new;
        end
      end
      if (cmd_i.commit) begin
        if (br_cnt_q != '1) begin
          br_cnt_q <= br_cnt_q + CntW'(1);
        end
        if (hit && (hit_cnt_q != '1)) begin
          hit_cnt_q <= hit_cnt_q + CntW'(1);
        end
      end
    end
  end

  assign sts_o.clr_last = &clr_addr_q;
  assign out_data_o     = {{OutPadW{1'b0}}, hit_cnt_q, br_cnt_q, out_hit_q, out_pred_q};

endmodule

`default_nettype wire

FILE: sv/branch_direction_predictor.sv
// top level of the branch direction predictor: controller plus datapath
// an accepted word passes local history read, counter read and commit, which waits for a
// free result register; the next word is taken only once the last one is committed
// reset: registers to mode bimodal, 10 index bits, 6 history bits, 2 counter bits,
//   counts zero; then a sweep of all 2^(MAX_INDEX_BITS+MAX_HISTORY_BITS) table entries
//   (65536 at defaults) sets every counter weakly taken and clears local histories
// every configuration write to a known register reruns that sweep; counts are kept
`timescale 1ns / 1ps
`default_nettype none

module branch_direction_predictor #(
  parameter int MAX_INDEX_BITS   = bdp_pkg::MaxIndexBitsDef,
  parameter int MAX_HISTORY_BITS = bdp_pkg::MaxHistoryBitsDef,
  parameter int MAX_COUNTER_BITS = bdp_pkg::MaxCounterBitsDef
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // input stream
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire  [bdp_pkg::InDataW-1:0]    s_axis_tdata,  // pc[63:0], taken[64], zero pad
  // result stream
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  output logic [bdp_pkg::OutDataW-1:0]   m_axis_tdata,  // predicted_taken[0], was_correct[1],
                                                        // branch_count[33:2],
                                                        // correct_count[65:34], zero pad
  // configuration writes
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire  [bdp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire  [bdp_pkg::CfgDataW-1:0]   cfg_data_i
);

  bdp_pkg::bdp_cmd_t cmd;
  bdp_pkg::bdp_sts_t sts;

  // sequencing: sweep, accept, slot formation, commit into result register
  bdp_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // tables, histories and counts; the result register sits here so the next
  // word may be taken while a result waits downstream
  bdp_dpath #(
    .MAX_INDEX_BITS   (MAX_INDEX_BITS),
    .MAX_HISTORY_BITS (MAX_HISTORY_BITS),
    .MAX_COUNTER_BITS (MAX_COUNTER_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

FILE: sv/bdp_checker.sv
// port-level checks for the branch predictor, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module bdp_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           s_axis_tvalid,
  input wire                           s_axis_tready,
  input wire                           m_axis_tvalid,
  input wire                           m_axis_tready,
  input wire [bdp_pkg::OutDataW-1:0]   m_axis_tdata,
  input wire                           cfg_valid_i,
  input wire                           cfg_ready_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // a configuration word and an input word are never taken together
  a_cfg_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !(cfg_valid_i && cfg_ready_o))
    else $error("input ready during configuration write");

  // one branch in flight: busy right after a word is taken
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready while a branch is in flight");

  // correct predictions never exceed branches seen
  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[65:34] <= m_axis_tdata[33:2]))
    else $error("correct count above branch count");

endmodule

bind branch_direction_predictor bdp_checker u_bdp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o)
);

`default_nettype wire
